// File: src/vpce_pkg.sv
// Shared constants, types and the arctangent table of the value-to-phase complex encoder.
`default_nettype none

package vpce_pkg;

    localparam int SAMPLE_W            = 16;
    localparam int OUT_W               = 17;
    localparam int MAG_W               = 16;
    localparam int PHASE_BITS          = 16;
    localparam int CORDIC_STAGES       = 16;
    localparam int DIV_STEPS           = MAG_W + PHASE_BITS;
    localparam int DIV_STEPS_PER_STAGE = 4;
    localparam int DIV_STAGES          =
        (DIV_STEPS + DIV_STEPS_PER_STAGE - 1) / DIV_STEPS_PER_STAGE;
    localparam int ANGLE_W             = 32;
    localparam int X0_W                = 32;
    localparam int XY_W                = 35;
    localparam int PROD_W              = MAG_W + X0_W;
    localparam int ROUND_SHIFT         = 16;
    localparam int OUT_LIMIT           = 65535;
    localparam int CFG_INDEX_W         = 2;
    localparam int ATAN_INDEX_W        = 5;

    localparam logic [X0_W-1:0] INV_GAIN = 32'd2608131496;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_RANGE_LOW  = 2'd0,
        CFG_RANGE_HIGH = 2'd1,
        CFG_AMPLITUDE  = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic valid;
        logic degen;
        logic neg;
    } ctl_t;

    function automatic logic [ANGLE_W-1:0] atan_turn(input logic [ATAN_INDEX_W-1:0] idx);
        logic [ANGLE_W-1:0] a;
        case (idx)
            5'd0:    a = 32'd536870912;
            5'd1:    a = 32'd316933406;
            5'd2:    a = 32'd167458907;
            5'd3:    a = 32'd85004756;
            5'd4:    a = 32'd42667331;
            5'd5:    a = 32'd21354465;
            5'd6:    a = 32'd10679838;
            5'd7:    a = 32'd5340245;
            5'd8:    a = 32'd2670163;
            5'd9:    a = 32'd1335087;
            5'd10:   a = 32'd667544;
            5'd11:   a = 32'd333772;
            5'd12:   a = 32'd166886;
            5'd13:   a = 32'd83443;
            5'd14:   a = 32'd41722;
            5'd15:   a = 32'd20861;
            5'd16:   a = 32'd10430;
            5'd17:   a = 32'd5215;
            5'd18:   a = 32'd2608;
            5'd19:   a = 32'd1304;
            5'd20:   a = 32'd652;
            5'd21:   a = 32'd326;
            5'd22:   a = 32'd163;
            5'd23:   a = 32'd81;
            default: a = '0;
        endcase
        return a;
    endfunction

endpackage

`default_nettype wire

// File: src/value_to_phase_complex_encoder.sv
// Top level of the value-to-phase complex encoder: registers, pipeline and rounded outputs.
// A sample goes through the front register, divider stages, start-vector register, rotation stages and output register.
// Throughput is one request per cycle unless the output stalls; divider and rotation stages are fully pipelined.
// The whole pipeline holds while a finished result is stalled at the output register.
// Reset clears all valid bits and loads range_low 0, range_high 32767 and amplitude 32767.
`default_nettype none

module value_to_phase_complex_encoder
    import vpce_pkg::*;
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       sample_valid,
    output logic                            sample_stall,
    input  wire logic signed [SAMPLE_W-1:0] sample,
    output logic                            result_valid,
    input  wire logic                       result_stall,
    output logic signed [OUT_W-1:0]         real_part,
    output logic signed [OUT_W-1:0]         imag_part,
    output logic                            degenerate_range,
    input  wire logic                       cfg_valid,
    output logic                            cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0]     cfg_index,
    input  wire logic [SAMPLE_W-1:0]        cfg_data
);

    logic signed [SAMPLE_W-1:0] range_low_reg;
    logic signed [SAMPLE_W-1:0] range_high_reg;
    logic [MAG_W-1:0]           amplitude_reg;

    logic signed [SAMPLE_W:0]   diff;
    logic [SAMPLE_W:0]          diff_abs;
    logic [MAG_W-1:0]           dmag;
    logic                       diff_neg;
    logic                       degen;
    logic                       en;

    ctl_t                       front_ctl;
    logic [MAG_W-1:0]           front_mag;
    ctl_t                       div_ctl;
    logic [PHASE_BITS-1:0]      div_quot;
    logic                       div_rem_nz;
    logic                       cor_valid;
    logic                       cor_degen;
    logic signed [XY_W-1:0]     cor_x;
    logic signed [XY_W-1:0]     cor_y;

    logic                       result_valid_reg;
    logic signed [OUT_W-1:0]    real_part_reg;
    logic signed [OUT_W-1:0]    imag_part_reg;
    logic                       degenerate_range_reg;
    logic signed [OUT_W-1:0]    real_part_next;
    logic signed [OUT_W-1:0]    imag_part_next;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            range_low_reg  <= '0;
            range_high_reg <= 16'sd32767;
            amplitude_reg  <= 16'd32767;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_reg_t'(cfg_index))
                CFG_RANGE_LOW:  range_low_reg  <= $signed(cfg_data);
                CFG_RANGE_HIGH: range_high_reg <= $signed(cfg_data);
                CFG_AMPLITUDE:  amplitude_reg  <= cfg_data;
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        diff     = {range_high_reg[SAMPLE_W-1], range_high_reg}
                 - {range_low_reg[SAMPLE_W-1], range_low_reg};
        diff_neg = diff[SAMPLE_W];
        diff_abs = diff_neg ? (SAMPLE_W+1)'(-diff) : diff;
        dmag     = diff_abs[MAG_W-1:0];
        degen    = (diff == '0);
    end

    assign en           = !(result_valid_reg && result_stall);
    assign sample_stall = !en;

    vpce_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .en           (en),
        .sample_valid (sample_valid),
        .sample       (sample),
        .range_low    (range_low_reg),
        .diff_neg     (diff_neg),
        .degen        (degen),
        .ctl          (front_ctl),
        .mag          (front_mag)
    );

    vpce_div u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .in_ctl  (front_ctl),
        .mag     (front_mag),
        .dmag    (dmag),
        .out_ctl (div_ctl),
        .quot    (div_quot),
        .rem_nz  (div_rem_nz)
    );

    vpce_cordic u_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_ctl    (div_ctl),
        .quot      (div_quot),
        .rem_nz    (div_rem_nz),
        .amplitude (amplitude_reg),
        .out_valid (cor_valid),
        .out_degen (cor_degen),
        .x_out     (cor_x),
        .y_out     (cor_y)
    );

    function automatic logic signed [OUT_W-1:0] round_sat(input logic signed [XY_W-1:0] v);
        logic signed [XY_W-1:0] r;
        logic signed [OUT_W-1:0] s;
        r = (v + XY_W'(32768)) >>> ROUND_SHIFT;
        if (r > $signed(XY_W'(OUT_LIMIT)))
        begin
            s = OUT_W'(OUT_LIMIT);
        end
        else if (r < $signed(-XY_W'(OUT_LIMIT)))
        begin
            s = -OUT_W'(OUT_LIMIT);
        end
        else
        begin
            s = r[OUT_W-1:0];
        end
        return s;
    endfunction

    always_comb
    begin
        if (cor_degen)
        begin
            real_part_next = -$signed({1'b0, amplitude_reg});
            imag_part_next = '0;
        end
        else
        begin
            real_part_next = round_sat(cor_x);
            imag_part_next = round_sat(cor_y);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            result_valid_reg <= cor_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            real_part_reg        <= real_part_next;
            imag_part_reg        <= imag_part_next;
            degenerate_range_reg <= cor_degen;
        end
    end

    assign result_valid     = result_valid_reg;
    assign real_part        = real_part_reg;
    assign imag_part        = imag_part_reg;
    assign degenerate_range = degenerate_range_reg;

    // A degenerate range always yields a zero imaginary part.
    a_degen_imag_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && degenerate_range |-> imag_part == '0)
        else $error("degenerate result with nonzero imaginary part");

    // Saturation never lets the most negative code through.
    a_saturated: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> real_part != -OUT_W'(OUT_LIMIT + 1)
                      && imag_part != -OUT_W'(OUT_LIMIT + 1))
        else $error("result outside the saturation limits");

    // A stalled result holds the whole pipeline, so no new request is taken.
    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |-> sample_stall)
        else $error("request accepted while the output is stalled");

    // A result that was stalled and is still present keeps its payload.
    a_held_result: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(real_part)
                                       && $stable(imag_part))
        else $error("stalled result changed inside the block");

endmodule

`default_nettype wire

// File: src/vpce_front.sv
// Input stage: offset of the sample from the low range bound, its magnitude and the quotient sign.
`default_nettype none

module vpce_front
    import vpce_pkg::*;
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       en,
    input  wire logic                       sample_valid,
    input  wire logic signed [SAMPLE_W-1:0] sample,
    input  wire logic signed [SAMPLE_W-1:0] range_low,
    input  wire logic                       diff_neg,
    input  wire logic                       degen,
    output ctl_t                            ctl,
    output logic [MAG_W-1:0]                mag
);

    logic signed [SAMPLE_W:0] num;
    logic [SAMPLE_W:0]        num_abs;
    ctl_t                     ctl_reg;
    ctl_t                     ctl_next;
    logic [MAG_W-1:0]         mag_reg;
    logic [MAG_W-1:0]         mag_next;

    always_comb
    begin
        num     = {sample[SAMPLE_W-1], sample} - {range_low[SAMPLE_W-1], range_low};
        num_abs = num[SAMPLE_W] ? (SAMPLE_W+1)'(-num) : num;
        mag_next = num_abs[MAG_W-1:0];
        ctl_next.valid = sample_valid;
        ctl_next.degen = degen;
        ctl_next.neg   = num[SAMPLE_W] ^ diff_neg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
            mag_reg <= '0;
        end
        else if (en)
        begin
            ctl_reg <= ctl_next;
            mag_reg <= mag_next;
        end
    end

    assign ctl = ctl_reg;
    assign mag = mag_reg;

endmodule

`default_nettype wire

// File: src/vpce_div.sv
// Pipelined restoring divider that yields the phase quotient modulo one turn and the remainder flag.
`default_nettype none

module vpce_div
    import vpce_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              en,
    input  wire ctl_t              in_ctl,
    input  wire logic [MAG_W-1:0]  mag,
    input  wire logic [MAG_W-1:0]  dmag,
    output ctl_t                   out_ctl,
    output logic [PHASE_BITS-1:0]  quot,
    output logic                   rem_nz
);

    ctl_t                  ctl_reg [DIV_STAGES];
    logic [MAG_W-1:0]      rem_reg [DIV_STAGES];
    logic [DIV_STEPS-1:0]  dvd_reg [DIV_STAGES];
    logic [PHASE_BITS-1:0] q_reg   [DIV_STAGES];

    ctl_t                  ctl_next [DIV_STAGES];
    logic [MAG_W-1:0]      rem_next [DIV_STAGES];
    logic [DIV_STEPS-1:0]  dvd_next [DIV_STAGES];
    logic [PHASE_BITS-1:0] q_next   [DIV_STAGES];

    for (genvar g = 0; g < DIV_STAGES; g++)
    begin : g_stage
        ctl_t                  ctl_in;
        logic [MAG_W-1:0]      rem_in;
        logic [DIV_STEPS-1:0]  dvd_in;
        logic [PHASE_BITS-1:0] q_in;
        logic [MAG_W:0]        trial;
        logic                  qbit;

        if (g == 0)
        begin : g_first
            assign ctl_in = in_ctl;
            assign rem_in = '0;
            assign dvd_in = {mag, {PHASE_BITS{1'b0}}};
            assign q_in   = '0;
        end
        else
        begin : g_chain
            assign ctl_in = ctl_reg[g-1];
            assign rem_in = rem_reg[g-1];
            assign dvd_in = dvd_reg[g-1];
            assign q_in   = q_reg[g-1];
        end

        always_comb
        begin
            ctl_next[g] = ctl_in;
            rem_next[g] = rem_in;
            dvd_next[g] = dvd_in;
            q_next[g]   = q_in;
            trial       = '0;
            qbit        = 1'b0;
            for (int k = 0; k < DIV_STEPS_PER_STAGE; k++)
            begin
                if (g * DIV_STEPS_PER_STAGE + k < DIV_STEPS)
                begin
                    trial       = {rem_next[g], dvd_next[g][DIV_STEPS-1]};
                    dvd_next[g] = dvd_next[g] << 1;
                    qbit        = (trial >= {1'b0, dmag});
                    if (qbit)
                    begin
                        trial = trial - {1'b0, dmag};
                    end
                    rem_next[g] = trial[MAG_W-1:0];
                    q_next[g]   = {q_next[g][PHASE_BITS-2:0], qbit};
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                ctl_reg[g] <= '0;
                rem_reg[g] <= '0;
                dvd_reg[g] <= '0;
                q_reg[g]   <= '0;
            end
            else if (en)
            begin
                ctl_reg[g] <= ctl_next[g];
                rem_reg[g] <= rem_next[g];
                dvd_reg[g] <= dvd_next[g];
                q_reg[g]   <= q_next[g];
            end
        end
    end

    assign out_ctl = ctl_reg[DIV_STAGES-1];
    assign quot    = q_reg[DIV_STAGES-1];
    assign rem_nz  = (rem_reg[DIV_STAGES-1] != '0);

endmodule

`default_nettype wire

// File: src/vpce_cordic.sv
// Phase folding, scaled start vector and the unrolled CORDIC rotation pipeline.
`default_nettype none

module vpce_cordic
    import vpce_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     en,
    input  wire ctl_t                     in_ctl,
    input  wire logic [PHASE_BITS-1:0]    quot,
    input  wire logic                     rem_nz,
    input  wire logic [MAG_W-1:0]         amplitude,
    output logic                          out_valid,
    output logic                          out_degen,
    output logic signed [XY_W-1:0]        x_out,
    output logic signed [XY_W-1:0]        y_out
);

    logic                      v_reg [CORDIC_STAGES+1];
    logic                      d_reg [CORDIC_STAGES+1];
    logic signed [XY_W-1:0]    x_reg [CORDIC_STAGES+1];
    logic signed [XY_W-1:0]    y_reg [CORDIC_STAGES+1];
    logic signed [ANGLE_W-1:0] z_reg [CORDIC_STAGES+1];

    logic signed [XY_W-1:0]    x_next [CORDIC_STAGES+1];
    logic signed [XY_W-1:0]    y_next [CORDIC_STAGES+1];
    logic signed [ANGLE_W-1:0] z_next [CORDIC_STAGES+1];

    logic [PHASE_BITS-1:0] phase;
    logic [ANGLE_W-1:0]    z_turn;
    logic                  fold;
    logic [PROD_W-1:0]     prod;
    logic [XY_W-1:0]       x0;

    // The phase is the quotient rounded toward minus infinity, then shifted by half a turn.
    always_comb
    begin
        if (in_ctl.neg)
        begin
            phase = rem_nz ? ~quot : PHASE_BITS'(-quot);
        end
        else
        begin
            phase = quot;
        end
        phase[PHASE_BITS-1] = ~phase[PHASE_BITS-1];
        z_turn = {phase, {(ANGLE_W-PHASE_BITS){1'b0}}};
        fold   = z_turn[ANGLE_W-1] ^ z_turn[ANGLE_W-2];
        if (fold)
        begin
            z_turn[ANGLE_W-1] = ~z_turn[ANGLE_W-1];
        end
        prod      = PROD_W'(amplitude) * PROD_W'(INV_GAIN);
        x0        = XY_W'(prod[PROD_W-1:ROUND_SHIFT]);
        x_next[0] = fold ? $signed(-x0) : $signed(x0);
        y_next[0] = '0;
        z_next[0] = $signed(z_turn);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            v_reg[0] <= in_ctl.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_reg[0] <= in_ctl.degen;
            x_reg[0] <= x_next[0];
            y_reg[0] <= y_next[0];
            z_reg[0] <= z_next[0];
        end
    end

    for (genvar g = 0; g < CORDIC_STAGES; g++)
    begin : g_rot
        logic signed [XY_W-1:0]    dx;
        logic signed [XY_W-1:0]    dy;
        logic signed [ANGLE_W-1:0] ang;

        always_comb
        begin
            dx  = y_reg[g] >>> g;
            dy  = x_reg[g] >>> g;
            ang = $signed(atan_turn(ATAN_INDEX_W'(g)));
            if (!z_reg[g][ANGLE_W-1])
            begin
                x_next[g+1] = x_reg[g] - dx;
                y_next[g+1] = y_reg[g] + dy;
                z_next[g+1] = z_reg[g] - ang;
            end
            else
            begin
                x_next[g+1] = x_reg[g] + dx;
                y_next[g+1] = y_reg[g] - dy;
                z_next[g+1] = z_reg[g] + ang;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[g+1] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[g+1] <= v_reg[g];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                d_reg[g+1] <= d_reg[g];
                x_reg[g+1] <= x_next[g+1];
                y_reg[g+1] <= y_next[g+1];
                z_reg[g+1] <= z_next[g+1];
            end
        end
    end

    assign out_valid = v_reg[CORDIC_STAGES];
    assign out_degen = d_reg[CORDIC_STAGES];
    assign x_out     = x_reg[CORDIC_STAGES];
    assign y_out     = y_reg[CORDIC_STAGES];

endmodule

`default_nettype wire

// File: sim/tb_value_to_phase_complex_encoder.sv
// Self-checking testbench for the value-to-phase complex encoder with its own bit-exact predictor.
`default_nettype none

module tb_value_to_phase_complex_encoder;
    import vpce_pkg::*;

    localparam int CYCLE_LIMIT   = 600000;
    localparam int TAIL_CYCLES   = 40;
    localparam int TABLE_ROWS    = 22;
    localparam int RAND_PHASES   = 11;
    localparam int PHASE_ITEMS   = 100;
    localparam int MAX_GAP       = 16;
    localparam int HOLD_CYCLES   = 240;
    localparam int MAX_PRINTS    = 60;

    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE = 2'd3;

    localparam logic [ANGLE_W-1:0] ATAN_Q32 [24] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
        32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
        32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
        32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163, 32'd81
    };

    typedef struct packed {
        logic signed [OUT_W-1:0] re;
        logic signed [OUT_W-1:0] im;
        logic                    dg;
    } phasor_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] lo;
        logic signed [SAMPLE_W-1:0] hi;
        logic [MAG_W-1:0]           amp;
        logic signed [SAMPLE_W-1:0] smp;
        logic                       typed;
        logic signed [OUT_W-1:0]    re;
        logic signed [OUT_W-1:0]    im;
        logic                       dg;
    } vector_t;

    logic                       clk;
    logic                       rst_n = 1'b0;
    logic                       sample_valid = 1'b0;
    logic                       sample_stall;
    logic signed [SAMPLE_W-1:0] sample = '0;
    logic                       result_valid;
    logic                       result_stall = 1'b0;
    logic signed [OUT_W-1:0]    real_part;
    logic signed [OUT_W-1:0]    imag_part;
    logic                       degenerate_range;
    logic                       cfg_valid = 1'b0;
    logic                       cfg_ready;
    logic [CFG_INDEX_W-1:0]     cfg_index = '0;
    logic [SAMPLE_W-1:0]        cfg_data = '0;

    logic signed [SAMPLE_W-1:0] lo_bound = 16'sd0;
    logic signed [SAMPLE_W-1:0] hi_bound = 16'sd32767;
    logic [MAG_W-1:0]           amp_set = 16'd32767;

    phasor_t owed [$];
    vector_t plan [TABLE_ROWS];

    int  errors = 0;
    int  samples_sent = 0;
    int  results_seen = 0;
    int  degen_seen = 0;
    int  stall_cycles = 0;
    int  cycle_count = 0;
    int  settings_used = 0;
    int  hold_request = 0;
    bit  src_idle = 1'b1;
    bit  snk_idle = 1'b1;

    value_to_phase_complex_encoder dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .sample_valid     (sample_valid),
        .sample_stall     (sample_stall),
        .sample           (sample),
        .result_valid     (result_valid),
        .result_stall     (result_stall),
        .real_part        (real_part),
        .imag_part        (imag_part),
        .degenerate_range (degenerate_range),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic logic signed [OUT_W-1:0] round_clip(input longint v);
        longint t;
        t = (v + 32768) >>> ROUND_SHIFT;
        if (t > OUT_LIMIT) t = OUT_LIMIT;
        if (t < -OUT_LIMIT) t = -OUT_LIMIT;
        return t[OUT_W-1:0];
    endfunction

    function automatic phasor_t phasor_of(input logic signed [SAMPLE_W-1:0] s);
        phasor_t            r;
        longint             span, num, x, y, zs, dx, dy;
        longint unsigned    mag, dmag, quo, ph;
        logic [ANGLE_W-1:0] z;
        bit                 neg;
        r = '0;
        span = longint'(hi_bound) - longint'(lo_bound);
        if (span == 0) begin
            num = amp_set;
            num = -num;
            r.re = num[OUT_W-1:0];
            r.dg = 1'b1;
            return r;
        end
        num = longint'(s) - longint'(lo_bound);
        neg = (num < 0) != (span < 0);
        mag = (num < 0) ? -num : num;
        mag = mag << PHASE_BITS;
        dmag = (span < 0) ? -span : span;
        quo = mag / dmag;
        if (neg && (mag % dmag) != 0) quo++;
        ph = neg ? -quo : quo;
        ph = (ph - (64'd1 << (PHASE_BITS - 1))) & ((64'd1 << PHASE_BITS) - 1);
        z = {ph[PHASE_BITS-1:0], {(ANGLE_W - PHASE_BITS){1'b0}}};
        mag = amp_set;
        mag = (mag * INV_GAIN) >> 16;
        x = longint'(mag);
        y = 0;
        if (z >= 32'h4000_0000 && z < 32'hC000_0000) begin
            x = -x;
            z = z - 32'h8000_0000;
        end
        zs = longint'($signed(z));
        for (int i = 0; i < CORDIC_STAGES; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (zs >= 0) begin
                x = x - dx;
                y = y + dy;
                zs = zs - longint'(ATAN_Q32[i]);
            end
            else begin
                x = x + dx;
                y = y - dy;
                zs = zs + longint'(ATAN_Q32[i]);
            end
        end
        r.re = round_clip(x);
        r.im = round_clip(y);
        return r;
    endfunction

    task automatic flag_mismatch(input string msg);
        if (errors < MAX_PRINTS) $display("mismatch at cycle %0d: %s", cycle_count, msg);
        errors++;
    endtask

    function automatic int draw_gap(input bit on);
        return on ? int'($urandom_range(0, MAX_GAP)) : 0;
    endfunction

    // Leaves cfg_valid high; the caller lowers it after its last write.
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [SAMPLE_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            CFG_RANGE_LOW:  lo_bound = val;
            CFG_RANGE_HIGH: hi_bound = val;
            CFG_AMPLITUDE:  amp_set = val;
            default: ;
        endcase
    endtask

    task automatic apply_config(input int lo, input int hi, input int amp);
        write_reg(CFG_RANGE_LOW, SAMPLE_W'(lo));
        write_reg(CFG_RANGE_HIGH, SAMPLE_W'(hi));
        write_reg(CFG_AMPLITUDE, MAG_W'(amp));
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    task automatic settle();
        sample_valid <= 1'b0;
        while (owed.size() != 0) @(posedge clk);
    endtask

    task automatic push_sample(input logic signed [SAMPLE_W-1:0] s, input bit typed,
                               input phasor_t want);
        int gap;
        gap = draw_gap(src_idle);
        if (gap > 0) begin
            sample_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sample_valid <= 1'b1;
        sample <= s;
        do @(posedge clk); while (sample_stall);
        owed.push_back(typed ? want : phasor_of(s));
        samples_sent++;
    endtask

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("TEST FAILED");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        phasor_t want;
        if (rst_n) begin
            if (sample_valid && sample_stall) stall_cycles++;
            if (result_valid && !result_stall) begin
                results_seen++;
                if (degenerate_range) degen_seen++;
                if (owed.size() == 0) begin
                    flag_mismatch("result with no request outstanding");
                end
                else begin
                    want = owed.pop_front();
                    if (real_part !== want.re)
                        flag_mismatch($sformatf("real_part %0d, expected %0d", real_part, want.re));
                    if (imag_part !== want.im)
                        flag_mismatch($sformatf("imag_part %0d, expected %0d", imag_part, want.im));
                    if (degenerate_range !== want.dg)
                        flag_mismatch($sformatf("degenerate_range %0b, expected %0b",
                                                degenerate_range, want.dg));
                end
            end
        end
    end

    initial
    begin
        int n;
        @(posedge rst_n);
        forever begin
            if (hold_request > 0) begin
                n = hold_request;
                hold_request = 0;
            end
            else begin
                n = draw_gap(snk_idle);
            end
            if (n > 0) begin
                result_stall <= 1'b1;
                repeat (n) @(posedge clk);
                result_stall <= 1'b0;
            end
            do @(posedge clk); while (!(result_valid && !result_stall));
        end
    end

    initial
    begin
        vector_t                    row;
        phasor_t                    want;
        int                         kind, lo, hi, amp, a, b, mn, mx;
        logic signed [SAMPLE_W-1:0] s;

        plan = '{
            '{0, 32767, 32767, 0, 0, 0, 0, 0},
            '{0, 32767, 32767, 16384, 0, 0, 0, 0},
            '{0, 32767, 32767, 32767, 0, 0, 0, 0},
            '{0, 32767, 32767, -32768, 0, 0, 0, 0},
            '{0, 32767, 32767, 8192, 0, 0, 0, 0},
            '{-32768, 32767, 65535, -32768, 0, 0, 0, 0},
            '{-32768, 32767, 65535, 32767, 0, 0, 0, 0},
            '{-32768, 32767, 65535, 0, 0, 0, 0, 0},
            '{-32768, 32767, 65535, -1, 0, 0, 0, 0},
            '{-32768, 32767, 65535, -16384, 0, 0, 0, 0},
            '{32767, -32768, 40000, 0, 0, 0, 0, 0},
            '{32767, -32768, 40000, 32767, 0, 0, 0, 0},
            '{32767, -32768, 40000, -32768, 0, 0, 0, 0},
            '{-32768, -32768, 65535, 5, 1, -65535, 0, 1},
            '{-32768, -32768, 65535, -32768, 1, -65535, 0, 1},
            '{32767, 32767, 1, 0, 1, -1, 0, 1},
            '{-100, 100, 0, 50, 1, 0, 0, 0},
            '{-100, 100, 0, 32767, 1, 0, 0, 0},
            '{0, 1, 12345, 0, 0, 0, 0, 0},
            '{0, 1, 12345, 1, 0, 0, 0, 0},
            '{0, 1, 12345, -32768, 0, 0, 0, 0},
            '{0, 1, 12345, 32767, 0, 0, 0, 0}
        };

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // The spare index must be ignored, so the reset settings still hold afterwards.
        write_reg(CFG_SPARE, 16'hFFFF);
        cfg_valid <= 1'b0;

        for (int k = 0; k < TABLE_ROWS; k++) begin
            row = plan[k];
            if (row.lo != lo_bound || row.hi != hi_bound || row.amp != amp_set) begin
                settle();
                apply_config(row.lo, row.hi, row.amp);
            end
            want = '{row.re, row.im, row.dg};
            push_sample(row.smp, row.typed, want);
        end

        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            settle();
            case (ph)
                0:       kind = 0;
                1:       kind = 2;
                3:       kind = 3;
                4:       kind = 4;
                default: kind = $urandom_range(0, 5);
            endcase
            a = int'($urandom_range(0, 65535)) - 32768;
            b = int'($urandom_range(0, 65535)) - 32768;
            if (a == b) b = (a == 32767) ? a - 1 : a + 1;
            mn = (a < b) ? a : b;
            mx = (a < b) ? b : a;
            case (kind)
                0: begin lo = -32768; hi = 32767; end
                1: begin lo = mn; hi = mx; end
                2: begin lo = mx; hi = mn; end
                3: begin lo = a; hi = a; end
                4: begin lo = int'($urandom_range(0, 65530)) - 32768; hi = lo + int'($urandom_range(1, 5)); end
                default: begin lo = a; hi = $urandom_range(0, 1) ? b : a; end
            endcase
            case ($urandom_range(0, 9))
                0:       amp = 0;
                1, 2:    amp = 65535;
                default: amp = $urandom_range(0, 65535);
            endcase
            if (kind == 0) amp = 65535;
            apply_config(lo, hi, amp);

            src_idle = (ph == 0 || ph == 2) ? 1'b0 : (ph == 1) ? 1'b1 : 1'($urandom_range(0, 1));
            snk_idle = (ph == 0) ? 1'b0 : (ph == 1) ? 1'b1 : 1'($urandom_range(0, 1));
            if (ph == 2) hold_request = HOLD_CYCLES;

            mn = (lo < hi) ? lo : hi;
            mx = (lo < hi) ? hi : lo;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if ($urandom_range(0, 3) == 0)
                    s = SAMPLE_W'($urandom_range(0, 65535));
                else
                    s = SAMPLE_W'(mn + int'($urandom_range(0, mx - mn)));
                push_sample(s, 1'b0, '0);
            end
        end

        settle();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (owed.size() != 0)
            flag_mismatch($sformatf("%0d results never arrived", owed.size()));

        $display("Sent %0d samples under %0d range settings; %0d results checked, %0d flagged degenerate.",
                 samples_sent, settings_used, results_seen, degen_seen);
        $display("Input was held off for %0d cycles, including one long output hold-off; %0d mismatches.",
                 stall_cycles, errors);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

`default_nettype wire
